// ----- rtl/core/aes128_pkg.sv -----
// AES-128 package: payload structs, S-box function, GF(2^8) helpers, round step functions.
// Used by every module of the block; depends on nothing.
package aes128_pkg;

  localparam int NumRoundsDef = 10;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 64;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_req_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_res_t;

  // forward S-box
  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return tbl[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit state, FIPS-197 order (byte 0 most significant)
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // SubBytes and ShiftRows
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(c*4+r) -: 8] = sbox(byte_at(s, ((c + r) % 4) * 4 + r));
      end
    end
    return t;
  endfunction

  // MixColumns
  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a, b, d, e, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a = byte_at(s, 4*c);
      b = byte_at(s, 4*c+1);
      d = byte_at(s, 4*c+2);
      e = byte_at(s, 4*c+3);
      al = a ^ b ^ d ^ e;
      t[127-32*c -: 8] = a ^ al ^ xtime(a ^ b);
      t[119-32*c -: 8] = b ^ al ^ xtime(b ^ d);
      t[111-32*c -: 8] = d ^ al ^ xtime(d ^ e);
      t[103-32*c -: 8] = e ^ al ^ xtime(e ^ a);
    end
    return t;
  endfunction

  // one key schedule step: next round key from previous and round constant
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ----- rtl/core/aes128_block_encrypt.sv -----
// A request is registered in the initial AddRoundKey stage, then passes the NUM_ROUNDS round stages to out_valid.
// Throughput: one block per cycle; busy never rises, one unrolled round stage
// per register stage sets the rate. Synchronous active-low reset clears the
// key registers and all valid bits; results cannot be stalled.
module aes128_block_encrypt #(
  parameter int NUM_ROUNDS = aes128_pkg::NumRoundsDef
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  aes128_pkg::in_req_t                  in_req,
  output logic                                 out_valid,
  output aes128_pkg::out_res_t                 out_res,
  input  logic                                 cfg_we,
  input  logic [aes128_pkg::CfgIdxW-1:0]       cfg_idx,
  input  logic [aes128_pkg::CfgDataW-1:0]      cfg_data
);
  import aes128_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  logic        vld_r;
  logic [127:0] state_r, key_r;

  logic         vld   [NUM_ROUNDS+1];
  logic [127:0] state [NUM_ROUNDS+1];
  logic [127:0] rkey  [NUM_ROUNDS+1];

  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegKeyHigh: key_high_r <= cfg_data;
        RegKeyLow: key_low_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // initial AddRoundKey stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= {in_req.block_high, in_req.block_low} ^ {key_high_r, key_low_r};
    key_r <= {key_high_r, key_low_r};
  end

  assign vld[0] = vld_r;
  assign state[0] = state_r;
  assign rkey[0] = key_r;

  // round stages
  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
    localparam logic [7:0] Rc = (g <= 8) ? 8'(1 << (g - 1)) : ((g == 9) ? 8'h1b : 8'h36);
    aes128_round #(
      .RCON (Rc),
      .LAST (g == NUM_ROUNDS)
    ) u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_i   (vld[g-1]),
      .state_i (state[g-1]),
      .key_i   (rkey[g-1]),
      .vld_o   (vld[g]),
      .state_o (state[g]),
      .key_o   (rkey[g])
    );
  end

  assign out_valid = vld[NUM_ROUNDS];
  assign out_res.cipher_high = state[NUM_ROUNDS][127:64];
  assign out_res.cipher_low = state[NUM_ROUNDS][63:0];

  // a registered request reaches out_valid through the NUM_ROUNDS round stages
  property p_latency;
    @(posedge clk) disable iff (!rst_n) vld_r |-> ##(NUM_ROUNDS) out_valid;
  endproperty
  a_latency: assert property (p_latency) else $error("result missing after pipeline");

  property p_no_spurious;
    @(posedge clk) disable iff (!rst_n) !vld_r |-> ##(NUM_ROUNDS) !out_valid;
  endproperty
  a_no_spurious: assert property (p_no_spurious) else $error("result without request");

  a_start_vld: assert property (@(posedge clk) disable iff (!rst_n) start |=> vld_r)
    else $error("request not captured");
endmodule

// ----- rtl/core/aes128_round.sv -----
// One pipelined AES round: key schedule step and state update, registered.
// Depends on aes128_pkg.
module aes128_round #(
  parameter logic [7:0] RCON = 8'h01,
  parameter bit LAST = 1'b0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [127:0] state_i,
  input  logic [127:0] key_i,
  output logic         vld_o,
  output logic [127:0] state_o,
  output logic [127:0] key_o
);
  import aes128_pkg::*;

  logic         vld_r;
  logic [127:0] state_r, state_nxt;
  logic [127:0] key_r, key_nxt;

  // compute round key and round output
  always_comb begin
    key_nxt = next_key(key_i, RCON);
    if (LAST) begin
      state_nxt = sub_shift(state_i) ^ key_nxt;
    end else begin
      state_nxt = mix(sub_shift(state_i)) ^ key_nxt;
    end
  end

  // advance valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    key_r <= key_nxt;
  end

  assign vld_o = vld_r;
  assign state_o = state_r;
  assign key_o = key_r;
endmodule

// ----- test/aes128_block_encrypt_chk.sv -----
// Checker for the AES-128 block encryptor: watches requests and results,
// computes expected ciphertext and compares. Depends on aes128_pkg for types.
`timescale 1ns / 100ps

module aes128_block_encrypt_chk (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  aes128_pkg::in_req_t   in_req,
  input  logic                  out_valid,
  input  aes128_pkg::out_res_t  out_res,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [63:0]           cfg_data,
  output int                    fail_count,
  output int                    cipher_pending
);
  import aes128_pkg::*;

  logic [7:0] sb_tbl [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  logic [63:0] key_hi_q, key_lo_q;
  out_res_t    cipher_q[$];

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Encrypt one block with a byte-array view of state and round keys.
  function automatic out_res_t encrypt_block(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] rcon, x, a, b, d, e, all;
    logic [127:0] ct;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ key[127-8*i -: 8];
    end
    // expand schedule word by word
    for (int p = 4; p < 44; p++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[(p-1)*4+j];
      if (p % 4 == 0) begin
        x = w[0];
        w[0] = sb_tbl[w[1]] ^ rcon;
        w[1] = sb_tbl[w[2]];
        w[2] = sb_tbl[w[3]];
        w[3] = sb_tbl[x];
        rcon = dbl(rcon);
      end
      for (int j = 0; j < 4; j++) rk[p*4+j] = rk[(p-4)*4+j] ^ w[j];
    end
    for (int r = 1; r <= 10; r++) begin
      // substitute and shift rows
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) tmp[c*4+q] = sb_tbl[st[((c+q)%4)*4+q]];
      st = tmp;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a = st[4*c]; b = st[4*c+1]; d = st[4*c+2]; e = st[4*c+3];
          all = a ^ b ^ d ^ e;
          st[4*c]   = a ^ all ^ dbl(a ^ b);
          st[4*c+1] = b ^ all ^ dbl(b ^ d);
          st[4*c+2] = d ^ all ^ dbl(d ^ e);
          st[4*c+3] = e ^ all ^ dbl(e ^ a);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
    return ct;
  endfunction

  assign cipher_pending = cipher_q.size();

  // Track key writes, queue expected ciphertext, compare results.
  always @(posedge clk) begin
    out_res_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected result %h", out_res);
          errs = errs + 1;
        end else begin
          want = cipher_q.pop_front();
          if (out_res.cipher_high !== want.cipher_high) begin
            $error("cipher_high expected %h actual %h", want.cipher_high, out_res.cipher_high);
            errs = errs + 1;
          end
          if (out_res.cipher_low !== want.cipher_low) begin
            $error("cipher_low expected %h actual %h", want.cipher_low, out_res.cipher_low);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (start && !busy)
        cipher_q.push_back(encrypt_block({key_hi_q, key_lo_q},
                                         {in_req.block_high, in_req.block_low}));
      if (cfg_we) begin
        if (cfg_idx == RegKeyHigh) key_hi_q <= cfg_data;
        else if (cfg_idx == RegKeyLow) key_lo_q <= cfg_data;
      end
    end
  end
endmodule

// ----- test/aes128_block_encrypt_tb.sv -----
// Testbench top for the AES-128 block encryptor: clock, reset, key writes and
// request stimulus. Depends on aes128_pkg, the block and its checker.
`timescale 1ns / 100ps

module aes128_block_encrypt_tb;
  import aes128_pkg::*;

  localparam int Latency = 11;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_req_t     in_req;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_we;
  logic        cfg_idx;
  logic [63:0] cfg_data;
  int          fail_count;
  int          cipher_pending;

  aes128_block_encrypt uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  aes128_block_encrypt_chk chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .cipher_pending(cipher_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: 1110 requests in all.
  initial begin
    #2000000;
    $display("aes128_block_encrypt: mismatch");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Hold one request until it is accepted; start is left high for idle_line or drain to drop.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    start <= 1'b1;
    in_req <= '{block_high: hi, block_low: lo};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_line(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait for the pipeline to drain before touching the key.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (cipher_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    write_reg(RegKeyHigh, hi);
    write_reg(RegKeyLow, lo);
    @(posedge clk);
  endtask

  // Random traffic in bursts; optionally back to back with no gaps.
  task automatic random_phase(input int count, input bit no_gaps);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && left > 0; i++) begin
        case ($urandom_range(0, 9))
          0: send_block('0, '1);
          1: send_block('1, rand64());
          default: send_block(rand64(), rand64());
        endcase
        left--;
      end
      if (!no_gaps) idle_line($urandom_range(0, 6));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_idx = RegKeyHigh;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key of all zeros
    send_block('0, '0);
    send_block('1, '1);
    drain();

    // standard known-answer vector, then key change between requests
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h8000000000000000, 64'h0000000000000001);
    send_block(64'h0000000000000001, 64'h8000000000000000);
    drain();
    load_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    drain();
    load_key('0, '1);
    send_block('1, '0);
    drain();
    // an ignored index does not exist here: both indexes are valid registers
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    drain();

    // random keys, random traffic, extremes in between
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        3: load_key('1, '0);
        7: load_key('0, '0);
        default: load_key(rand64(), rand64());
      endcase
      random_phase(100, ph % 4 == 2);
      drain();
    end

    repeat (Latency + 4) @(posedge clk);
    if (fail_count == 0 && cipher_pending == 0) begin
      $display("aes128_block_encrypt: match");
    end else begin
      $display("aes128_block_encrypt: mismatch");
    end
    $finish;
  end
endmodule
